// ===== sv/lz10_pkg.sv =====
// ----------------------------------------------------------------------------
// lz10_pkg
// Shared constants for the LZ10 stream decompressor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lz10_pkg;

  localparam int BYTE_W       = 8;
  localparam int WINDOW_DEPTH = 4096;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = PTR_W + 1;
  localparam int DIST_W       = PTR_W + 1;
  localparam int LEN_W        = 24;
  localparam int COPY_W       = 5;
  localparam int TOKEN_W      = 4;
  localparam int HDR_W        = 2;

  localparam int MATCH_MIN    = 3;
  localparam int FLAG_TOKENS  = 8;
  localparam int HDR_LAST     = 2;

endpackage

`default_nettype wire

// ===== sv/lz10_in_if.sv =====
// ----------------------------------------------------------------------------
// lz10_in_if
// Compressed byte channel: valid/ready handshake, one byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lz10_in_if
  import lz10_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_stream;

  modport source (output valid, output data_byte, output start_of_stream, input ready);
  modport sink   (input valid, input data_byte, input start_of_stream, output ready);
endinterface

`default_nettype wire

// ===== sv/lz10_out_if.sv =====
// ----------------------------------------------------------------------------
// lz10_out_if
// Decompressed byte channel: valid/ready handshake, one byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lz10_out_if
  import lz10_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_stream;
  logic              last_of_item;
  logic              ref_error;

  modport source (output valid, output out_byte, output last_of_stream,
                  output last_of_item, output ref_error, input ready);
  modport sink   (input valid, input out_byte, input last_of_stream,
                  input last_of_item, input ref_error, output ready);
endinterface

`default_nettype wire

// ===== sv/lz10_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// lz10_decompressor_core
// LZ10 (LZ77 type 0x10) decompressor, one compressed byte per input word.
// ----------------------------------------------------------------------------
// Feed the compressed stream one byte per word, with start_of_stream set on
// the type byte; a start word abandons any stream in progress. Header and flag
// bytes produce nothing, a literal produces one word, and the low byte of a
// back reference starts a copy of L bytes (L = 3..18) out of the 4096-byte
// history memory through its single registered read port, at one byte per
// cycle while the output is not stalled. Bytes past the declared length are
// dropped. The history reads as zeros after reset without a clearing pass:
// a fill count marks which entries have been written. ref_error flags copied
// bytes taken from before the current stream's first output.
`timescale 1ns / 1ps
`default_nettype none

module lz10_decompressor_core
  import lz10_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  lz10_in_if.sink     compressed,
  lz10_out_if.source  decompressed
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_REFLOW,
    PH_COPY
  } phase_t;

  phase_t              phase;
  logic [HDR_W-1:0]    header_count;
  logic [BYTE_W-1:0]   flag_bits;
  logic [TOKEN_W-1:0]  tokens_left;
  logic [BYTE_W-1:0]   saved_high_byte;
  logic [LEN_W-1:0]    bytes_remaining;
  logic [LEN_W-1:0]    bytes_produced;
  logic [PTR_W-1:0]    write_pointer;
  logic [FILL_W-1:0]   fill_count;
  logic [COPY_W-1:0]   copy_left;
  logic [PTR_W-1:0]    copy_src;
  logic [DIST_W-1:0]   copy_dist;

  logic [BYTE_W-1:0]   ring [WINDOW_DEPTH];
  logic [BYTE_W-1:0]   rd_q;
  logic                rd_zero;
  logic                fwd;
  logic [BYTE_W-1:0]   fwd_data;

  logic                out_valid;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last_stream;
  logic                out_last_item;
  logic                out_err;

  logic                slot_free;
  logic                in_ready;
  logic                in_fire;
  logic                lit_fire;
  logic                ref_lo_fire;
  logic                copy_fire;
  logic                emit;
  logic [BYTE_W-1:0]   copy_byte;
  logic [BYTE_W-1:0]   emit_byte;
  logic                emit_err;
  logic [LEN_W-1:0]    remaining_dec;
  logic                stream_done;
  logic                copy_last;
  logic                emit_last_item;
  logic [DIST_W-1:0]   ref_dist;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [TOKEN_W-1:0]  tokens_dec;
  phase_t              token_phase;
  logic [LEN_W-1:0]    header_value;

  assign slot_free   = !out_valid || decompressed.ready;
  assign in_ready    = (phase != PH_COPY) && slot_free;
  assign in_fire     = compressed.valid && in_ready;
  assign lit_fire    = in_fire && !compressed.start_of_stream && (phase == PH_TOKEN)
                       && !flag_bits[BYTE_W-1];
  assign ref_lo_fire = in_fire && !compressed.start_of_stream && (phase == PH_REFLOW);
  assign copy_fire   = (phase == PH_COPY) && slot_free;
  assign emit        = lit_fire || copy_fire;

  assign copy_byte      = fwd ? fwd_data : (rd_zero ? '0 : rd_q);
  assign emit_byte      = lit_fire ? compressed.data_byte : copy_byte;
  assign emit_err       = copy_fire && ({{(LEN_W-DIST_W){1'b0}}, copy_dist} > bytes_produced);
  assign remaining_dec  = bytes_remaining - LEN_W'(1);
  assign stream_done    = (remaining_dec == '0);
  assign copy_last      = copy_fire && (stream_done || (copy_left == COPY_W'(1)));
  assign emit_last_item = lit_fire || copy_last;

  assign ref_dist = {1'b0, saved_high_byte[3:0], compressed.data_byte} + DIST_W'(1);
  assign rd_en    = ref_lo_fire || (copy_fire && !copy_last);
  assign rd_addr  = ref_lo_fire ? (write_pointer - ref_dist[PTR_W-1:0])
                                : (copy_src + PTR_W'(1));

  assign tokens_dec   = tokens_left - TOKEN_W'(1);
  assign token_phase  = (tokens_dec == '0) ? PH_FLAG : PH_TOKEN;
  assign header_value = bytes_remaining
                        | (LEN_W'(compressed.data_byte) << {header_count, 3'b000});

  assign compressed.ready            = in_ready;
  assign decompressed.valid          = out_valid;
  assign decompressed.out_byte       = out_byte;
  assign decompressed.last_of_stream = out_last_stream;
  assign decompressed.last_of_item   = out_last_item;
  assign decompressed.ref_error      = out_err;

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (emit) begin
      ring[write_pointer] <= emit_byte;
    end
    if (rd_en) begin
      rd_q     <= ring[rd_addr];
      // bypass a read of the entry being written this cycle
      fwd      <= emit && (rd_addr == write_pointer);
      fwd_data <= emit_byte;
      // entries never written since reset read as zero
      rd_zero  <= !fill_count[FILL_W-1] && (rd_addr >= fill_count[PTR_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte        <= emit_byte;
      out_last_stream <= stream_done;
      out_last_item   <= emit_last_item;
      out_err         <= emit_err;
    end
    if (rd_en) begin
      copy_src <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_count    <= '0;
      flag_bits       <= '0;
      tokens_left     <= '0;
      saved_high_byte <= '0;
      bytes_remaining <= '0;
      bytes_produced  <= '0;
      write_pointer   <= '0;
      fill_count      <= '0;
      copy_left       <= '0;
      copy_dist       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (decompressed.ready) begin
        out_valid <= 1'b0;
      end

      if (emit) begin
        write_pointer   <= write_pointer + PTR_W'(1);
        bytes_produced  <= bytes_produced + LEN_W'(1);
        bytes_remaining <= remaining_dec;
        if (!fill_count[FILL_W-1]) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end

      if (in_fire) begin
        if (compressed.start_of_stream) begin
          phase           <= PH_HEADER;
          header_count    <= '0;
          bytes_remaining <= '0;
          bytes_produced  <= '0;
          flag_bits       <= '0;
          tokens_left     <= '0;
        end else begin
          case (phase)
            PH_HEADER: begin
              bytes_remaining <= header_value;
              if (header_count >= HDR_W'(HDR_LAST)) begin
                header_count <= '0;
                phase        <= (header_value == '0) ? PH_IDLE : PH_FLAG;
              end else begin
                header_count <= header_count + HDR_W'(1);
              end
            end
            PH_FLAG: begin
              flag_bits   <= compressed.data_byte;
              tokens_left <= TOKEN_W'(FLAG_TOKENS);
              phase       <= PH_TOKEN;
            end
            PH_TOKEN: begin
              if (!flag_bits[BYTE_W-1]) begin
                if (stream_done) begin
                  phase <= PH_IDLE;
                end else begin
                  flag_bits   <= flag_bits << 1;
                  tokens_left <= tokens_dec;
                  phase       <= token_phase;
                end
              end else begin
                saved_high_byte <= compressed.data_byte;
                phase           <= PH_REFLOW;
              end
            end
            PH_REFLOW: begin
              copy_dist <= ref_dist;
              copy_left <= {1'b0, saved_high_byte[7:4]} + COPY_W'(MATCH_MIN);
              phase     <= PH_COPY;
            end
            default: begin
            end
          endcase
        end
      end

      if (copy_fire) begin
        copy_left <= copy_left - COPY_W'(1);
        if (copy_last) begin
          if (stream_done) begin
            phase <= PH_IDLE;
          end else begin
            flag_bits   <= flag_bits << 1;
            tokens_left <= tokens_dec;
            phase       <= token_phase;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lz10_checker.sv =====
// ----------------------------------------------------------------------------
// lz10_checker
// Port-level checks on the decompressor, attached to the core module by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lz10_checker
  import lz10_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_start,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic              out_last_stream,
  input wire logic              out_last_item
);

  // a stalled output word holds its byte
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled output word changed");

  // input is taken only when the output slot is free or draining
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid && !out_ready))
    else $error("input ready while output word is stalled");

  // a start word produces nothing
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_start |=> !out_valid)
    else $error("output word after start word");

  // the end of a stream also closes the input word's results
  a_last_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last_stream |-> out_last_item)
    else $error("last_of_stream without last_of_item");

  // a copy in progress keeps streaming and holds off input
  a_copy_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last_item |-> !in_ready ##1 out_valid)
    else $error("copy gap or input taken mid-copy");

endmodule

bind lz10_decompressor_core lz10_checker u_lz10_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (compressed.valid),
  .in_ready        (compressed.ready),
  .in_start        (compressed.start_of_stream),
  .out_valid       (decompressed.valid),
  .out_ready       (decompressed.ready),
  .out_byte        (decompressed.out_byte),
  .out_last_stream (decompressed.last_of_stream),
  .out_last_item   (decompressed.last_of_item)
);

`default_nettype wire

// ===== dv/tb_lz10_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// tb_lz10_decompressor_core
// Self-checking bench for the LZ10 decompressor core. A scoreboard expands
// every accepted compressed word into the bytes it must produce. Each
// decompressed word is then checked against the oldest pending byte. The
// stimulus opens with directed streams, followed by random streams: mostly
// well formed, some broken or noisy. Both handshakes stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lz10_decompressor_core;
  import lz10_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 250;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_COPY
  } expand_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_stream;
    logic              last_of_item;
    logic              ref_error;
  } out_word_t;

  class inflate_scoreboard;
    out_word_t         pending[$];
    logic [BYTE_W-1:0] ring [WINDOW_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    expand_phase_t     phase;
    logic [HDR_W-1:0]  hdr_idx;
    logic [BYTE_W-1:0] flags;
    logic [3:0]        tokens_left;
    logic [BYTE_W-1:0] ref_hi;
    logic [LEN_W-1:0]  remaining;
    logic [LEN_W-1:0]  produced;
    int unsigned       mismatches;
    int unsigned       matched;
    int unsigned       flagged;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr      = '0;
      phase       = PH_IDLE;
      hdr_idx     = '0;
      flags       = '0;
      tokens_left = '0;
      ref_hi      = '0;
      remaining   = '0;
      produced    = '0;
      mismatches  = 0;
      matched     = 0;
      flagged     = 0;
    endfunction

    // Write one output byte to history; returns 1 when the stream just ended.
    function bit emit_byte(logic [BYTE_W-1:0] b, logic err);
      out_word_t w;
      ring[wr_ptr] = b;
      wr_ptr       = wr_ptr + 1'b1;
      produced     = produced + 1'b1;
      remaining    = remaining - 1'b1;
      w.out_byte       = b;
      w.last_of_stream = (remaining == '0);
      w.last_of_item   = 1'b0;
      w.ref_error      = err;
      pending.push_back(w);
      if (remaining == '0) begin
        phase = PH_IDLE;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void advance_token();
      if (phase == PH_IDLE) return;
      flags       = flags << 1;
      tokens_left = tokens_left - 1'b1;
      phase       = (tokens_left == '0) ? PH_FLAG : PH_TOKEN;
    endfunction

    // Expand one accepted compressed word; returns 1 if the core used it.
    function bit note_word(logic [BYTE_W-1:0] b, logic sos);
      bit               took;
      int               first_new;
      int unsigned      copy_len;
      logic [DIST_W-1:0] back_dist;
      logic [PTR_W-1:0] rd_ptr;
      took      = sos || (phase != PH_IDLE);
      first_new = pending.size();
      if (sos) begin
        phase       = PH_HEADER;
        hdr_idx     = '0;
        remaining   = '0;
        produced    = '0;
        flags       = '0;
        tokens_left = '0;
        return took;
      end
      case (phase)
        PH_HEADER: begin
          remaining = remaining | (LEN_W'(b) << (8 * hdr_idx));
          if (hdr_idx >= HDR_W'(HDR_LAST)) begin
            hdr_idx = '0;
            phase   = (remaining == '0) ? PH_IDLE : PH_FLAG;
          end else begin
            hdr_idx = hdr_idx + 1'b1;
          end
        end
        PH_FLAG: begin
          flags       = b;
          tokens_left = 4'(FLAG_TOKENS);
          phase       = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (!flags[BYTE_W-1]) begin
            void'(emit_byte(b, 1'b0));
            advance_token();
          end else begin
            ref_hi = b;
            phase  = PH_COPY;
          end
        end
        PH_COPY: begin
          copy_len  = int'(ref_hi[7:4]) + MATCH_MIN;
          back_dist = {1'b0, ref_hi[3:0], b} + 1'b1;
          for (int j = 0; j < copy_len; j++) begin
            rd_ptr = wr_ptr - back_dist[PTR_W-1:0];
            if (emit_byte(ring[rd_ptr], LEN_W'(back_dist) > produced)) break;
          end
          advance_token();
        end
        default: ;
      endcase
      if (pending.size() > first_new) pending[$].last_of_item = 1'b1;
      return took;
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output word byte=%02h los=%b loi=%b err=%b",
                 $time, got.out_byte, got.last_of_stream, got.last_of_item,
                 got.ref_error);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte || got.last_of_stream !== want.last_of_stream ||
          got.last_of_item !== want.last_of_item || got.ref_error !== want.ref_error) begin
        $display("%0t: mismatch expected byte=%02h los=%b loi=%b err=%b", $time,
                 want.out_byte, want.last_of_stream, want.last_of_item, want.ref_error);
        $display("%0t:          actual   byte=%02h los=%b loi=%b err=%b", $time,
                 got.out_byte, got.last_of_stream, got.last_of_item, got.ref_error);
        mismatches++;
      end else begin
        matched++;
        if (want.ref_error) flagged++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lz10_in_if  cin ();
  lz10_out_if cout ();

  lz10_decompressor_core dut (
    .clk          (clk),
    .rst          (rst),
    .compressed   (cin.sink),
    .decompressed (cout.source)
  );

  inflate_scoreboard sb;
  bit                calm;
  int unsigned       words_taken;
  int unsigned       streams_sent;
  int unsigned       cycles;
  out_word_t         seen;
  bit                seen_valid;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit stall_roll();
    return !calm && ($urandom_range(99) < 36);
  endfunction

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic sos);
    calm = (words_taken >= 120) && (words_taken < 180);
    if (stall_roll()) begin
      cin.valid <= 1'b0;
      do @(posedge clk); while (stall_roll());
    end
    cin.valid           <= 1'b1;
    cin.data_byte       <= b;
    cin.start_of_stream <= sos;
    do @(posedge clk); while (!cin.ready);
    if (sb.note_word(b, sos)) words_taken++;
  endtask

  task automatic send_stream();
    int unsigned roll;
    int unsigned target;
    int unsigned made;
    int unsigned copy_len;
    int unsigned back_dist;
    logic [BYTE_W-1:0] flag;
    roll = $urandom_range(99);
    streams_sent++;
    if (roll < 4) begin
      // noise between streams, dropped by the core unless a broken stream is still open
      repeat ($urandom_range(1, 4)) send_word(8'($urandom), 1'b0);
      return;
    end
    send_word(8'($urandom), 1'b1);
    if (roll < 8) begin
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      return;
    end
    if (roll < 18) begin
      // broken: random header, possibly cut short, abandoned by the next start
      repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
      repeat ($urandom_range(0, 10)) send_word(8'($urandom), 1'b0);
      return;
    end
    target = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
    send_word(target[7:0], 1'b0);
    send_word(target[15:8], 1'b0);
    send_word(target[23:16], 1'b0);
    made = 0;
    while (made < target) begin
      flag = 8'($urandom);
      send_word(flag, 1'b0);
      for (int t = 0; t < FLAG_TOKENS && made < target; t++) begin
        if (!flag[7 - t]) begin
          send_word(8'($urandom), 1'b0);
          made++;
        end else begin
          copy_len = $urandom_range(MATCH_MIN, 18);
          if (made > 0 && $urandom_range(99) < 85)
            back_dist = $urandom_range(1, (made < WINDOW_DEPTH) ? made : WINDOW_DEPTH);
          else
            back_dist = $urandom_range(1, WINDOW_DEPTH);
          send_word(8'(((copy_len - MATCH_MIN) << 4) | ((back_dist - 1) >> 8)), 1'b0);
          send_word(8'((back_dist - 1) & 8'hFF), 1'b0);
          made += copy_len;
        end
      end
    end
    if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
  endtask

  // Capture at the edge, check a moment later so the input side is noted first.
  initial begin
    cout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      seen_valid          = !rst && cout.valid && cout.ready;
      seen.out_byte       = cout.out_byte;
      seen.last_of_stream = cout.last_of_stream;
      seen.last_of_item   = cout.last_of_item;
      seen.ref_error      = cout.ref_error;
      cout.ready <= calm || ($urandom_range(99) >= 36);
      if (seen_valid) begin
        #1;
        sb.check_word(seen);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d bytes still pending", cycles, sb.pending.size());
    $display("tb_lz10_decompressor_core failed");
    $finish;
  end

  initial begin
    sb           = new();
    calm         = 1'b0;
    words_taken  = 0;
    streams_sent = 0;
    cin.valid           <= 1'b0;
    cin.data_byte       <= '0;
    cin.start_of_stream <= 1'b0;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // drop before any start, then a zero-length stream and a trailing drop
    send_word(8'h5A, 1'b0);
    send_word(8'h10, 1'b1);
    send_word(8'h00, 1'b0); send_word(8'h00, 1'b0); send_word(8'h00, 1'b0);
    send_word(8'h77, 1'b0);
    // length 8: literal, short copy, then an early max copy cut at the length
    send_word(8'hFF, 1'b1);
    send_word(8'h08, 1'b0); send_word(8'h00, 1'b0); send_word(8'h00, 1'b0);
    send_word(8'h60, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0); send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0); send_word(8'hFF, 1'b0);
    send_word(8'hAB, 1'b0);
    // length 32, left unfinished: the next start abandons it
    send_word(8'h10, 1'b1);
    send_word(8'h20, 1'b0); send_word(8'h00, 1'b0); send_word(8'h00, 1'b0);
    send_word(8'h30, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hF0, 1'b0); send_word(8'h01, 1'b0);
    streams_sent = 3;

    while (words_taken < RANDOM_WORDS + 25) send_stream();
    cin.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d streams, %0d compressed words, %0d output bytes checked",
             streams_sent, words_taken, sb.matched);
    $display("including %0d bytes copied from before their stream start", sb.flagged);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_lz10_decompressor_core passed");
    end else begin
      $display("tb_lz10_decompressor_core failed");
    end
    $finish;
  end

endmodule

// ===== lz10_decompressor_core.f =====
sv/lz10_pkg.sv
sv/lz10_in_if.sv
sv/lz10_out_if.sv
sv/lz10_decompressor_core.sv
sv/lz10_checker.sv
dv/tb_lz10_decompressor_core.sv
